>>> hdl/gmsd_pkg.sv
`default_nettype none
package gmsd_pkg;

   localparam int MAX_SERVERS = 64;
   localparam int IDX_W       = $clog2(MAX_SERVERS);
   localparam int CNT_W       = 7;
   localparam int AMT_W       = 10;
   localparam int TIME_W      = 32;
   localparam int PROD_W      = 2 * AMT_W;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_JOB  = 1'b1;

   typedef logic [TIME_W-1:0] time_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [AMT_W-1:0]  amt_type;

   // Running result of the scan that travels down the row of cells.
   typedef struct packed {
      logic     valid;
      time_type min_time;
      idx_type  min_idx;
      amt_type  min_rate;
      logic     found;
      idx_type  found_idx;
      amt_type  found_rate;
   } token_type;

   // Write bus shared by every cell; each cell matches the index itself.
   typedef struct packed {
      logic     rate_we;
      logic     free_we;
      logic     clear;
      idx_type  idx;
      amt_type  rate_val;
      time_type free_val;
   } wr_bus_type;

endpackage
`default_nettype wire

>>> hdl/greedy_multi_server_job_dispatcher.sv
`default_nettype none
// Greedy job dispatcher over up to 64 servers, each held in one cell of a row.
// A rate load (cmd 0) is written into its cell and gives no response. A job (cmd 1)
// sends a scan token down the whole row of 64 cells, one cell per cycle, which
// finds the earliest free time and the first server already free at the current
// clock; a multiply state and a saturating-add state follow, and then the response
// is registered. No new request is taken until the job is done and the block is idle.
// A new request is taken while a response still waits; the block holds a finished
// job only if the previous response has not yet been taken.
module greedy_multi_server_job_dispatcher (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_cmd,
   input  wire logic [5:0]              req_server_index,
   input  wire logic [9:0]              req_amount,
   input  wire logic                    req_end_of_batch,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [5:0]                   rsp_chosen_server,
   output logic [31:0]                  rsp_start_time,
   output logic [31:0]                  rsp_finish_time,
   output logic [31:0]                  rsp_makespan,
   output logic                         rsp_batch_done,
   input  wire logic                    csr_write_enable,
   input  wire logic [6:0]              csr_write_data
);
   import gmsd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] num_servers_ff;
   logic [CNT_W-1:0] n_count;
   logic             launch_ff, launch_in;
   amt_type          amount_ff, amount_in;
   logic             eob_ff, eob_in;
   time_type         start_ff, start_in;
   idx_type          chosen_ff, chosen_in;
   amt_type          rate_ff, rate_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   time_type         clock_now_ff, clock_now_in;
   time_type         longest_ff, longest_in;

   logic             rsp_valid_ff, rsp_valid_in;
   idx_type          rsp_chosen_ff, rsp_chosen_in;
   time_type         rsp_start_ff, rsp_start_in;
   time_type         rsp_finish_ff, rsp_finish_in;
   time_type         rsp_make_ff, rsp_make_in;
   logic             rsp_done_ff, rsp_done_in;

   logic             accept;
   logic             slot_free;
   logic [TIME_W:0]  sum;
   time_type         fin;
   time_type         new_longest;
   wr_bus_type       wr_bus;
   token_type        seed_tok;
   token_type        tok [0:MAX_SERVERS];

   // Zero servers is treated as one; anything above the row length is capped.
   always_comb begin
      if (num_servers_ff == '0) begin
         n_count = CNT_W'(1);
      end else if (num_servers_ff > CNT_W'(MAX_SERVERS)) begin
         n_count = CNT_W'(MAX_SERVERS);
      end else begin
         n_count = num_servers_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign sum         = {1'b0, start_ff} + {{(TIME_W + 1 - PROD_W){1'b0}}, prod_ff};
   assign fin         = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
   assign new_longest = (fin > longest_ff) ? fin : longest_ff;

   always_comb begin
      seed_tok          = '0;
      seed_tok.valid    = launch_ff;
      seed_tok.min_time = '1;
   end

   assign tok[0] = seed_tok;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_SERVERS; gi++) begin : g_cell
         gmsd_cell u_cell (
            .clock          (clock),
            .reset          (reset),
            .cell_index     (IDX_W'(gi)),
            .servers_in_use (n_count),
            .threshold      (clock_now_ff),
            .wr_bus         (wr_bus),
            .tok_in         (tok[gi]),
            .tok_out        (tok[gi+1])
         );
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      launch_in     = 1'b0;
      amount_in     = amount_ff;
      eob_in        = eob_ff;
      start_in      = start_ff;
      chosen_in     = chosen_ff;
      rate_in       = rate_ff;
      prod_in       = prod_ff;
      clock_now_in  = clock_now_ff;
      longest_in    = longest_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_finish_in = rsp_finish_ff;
      rsp_make_in   = rsp_make_ff;
      rsp_done_in   = rsp_done_ff;
      wr_bus          = '0;
      wr_bus.idx      = req_server_index;
      wr_bus.rate_val = req_amount;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_LOAD) begin
                  wr_bus.rate_we = 1'b1;
               end else begin
                  amount_in = req_amount;
                  eob_in    = req_end_of_batch;
                  launch_in = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (tok[MAX_SERVERS].valid) begin
               // A server free by the current clock means the start stays at the clock.
               if (tok[MAX_SERVERS].found) begin
                  start_in  = clock_now_ff;
                  chosen_in = tok[MAX_SERVERS].found_idx;
                  rate_in   = tok[MAX_SERVERS].found_rate;
               end else begin
                  start_in  = tok[MAX_SERVERS].min_time;
                  chosen_in = tok[MAX_SERVERS].min_idx;
                  rate_in   = tok[MAX_SERVERS].min_rate;
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(rate_ff) * PROD_W'(amount_ff);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_chosen_in = chosen_ff;
               rsp_start_in  = start_ff;
               rsp_finish_in = fin;
               rsp_make_in   = new_longest;
               rsp_done_in   = eob_ff;
               wr_bus.idx      = chosen_ff;
               wr_bus.free_val = fin;
               if (eob_ff) begin
                  wr_bus.clear = 1'b1;
                  clock_now_in = '0;
                  longest_in   = '0;
               end else begin
                  wr_bus.free_we = 1'b1;
                  clock_now_in   = start_ff;
                  longest_in     = new_longest;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         launch_ff      <= 1'b0;
         num_servers_ff <= CNT_W'(1);
         clock_now_ff   <= '0;
         longest_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         clock_now_ff <= clock_now_in;
         longest_ff   <= longest_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            num_servers_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      amount_ff     <= amount_in;
      eob_ff        <= eob_in;
      start_ff      <= start_in;
      chosen_ff     <= chosen_in;
      rate_ff       <= rate_in;
      prod_ff       <= prod_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_finish_ff <= rsp_finish_in;
      rsp_make_ff   <= rsp_make_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_server = rsp_chosen_ff;
   assign rsp_start_time    = rsp_start_ff;
   assign rsp_finish_time   = rsp_finish_ff;
   assign rsp_makespan      = rsp_make_ff;
   assign rsp_batch_done    = rsp_done_ff;

   a_finish_after_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_finish_ff >= rsp_start_ff)
      else $error("finish time earlier than start time");

   a_makespan_covers_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_make_ff >= rsp_finish_ff)
      else $error("makespan below finish time");

   a_token_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[MAX_SERVERS].valid |-> state_ff == ST_SCAN)
      else $error("scan token left the row outside a scan");

   a_launch_once: assert property (@(posedge clock) disable iff (reset)
      launch_ff |=> !launch_ff)
      else $error("scan token launched twice");

endmodule
`default_nettype wire

>>> hdl/gmsd_cell.sv
`default_nettype none
module gmsd_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire gmsd_pkg::idx_type      cell_index,
   input  wire logic [gmsd_pkg::CNT_W-1:0] servers_in_use,
   input  wire gmsd_pkg::time_type     threshold,
   input  wire gmsd_pkg::wr_bus_type   wr_bus,
   input  wire gmsd_pkg::token_type    tok_in,
   output gmsd_pkg::token_type         tok_out
);
   import gmsd_pkg::*;

   time_type  free_ff, free_in;
   amt_type   rate_ff, rate_in;
   token_type tok_ff, tok_in_merged;
   logic      active;
   logic      hit;

   assign hit    = (wr_bus.idx == cell_index);
   assign active = ({{(CNT_W-IDX_W){1'b0}}, cell_index} < servers_in_use);

   always_comb begin
      free_in = free_ff;
      rate_in = rate_ff;
      if (wr_bus.clear) begin
         free_in = '0;
      end else if (wr_bus.free_we && hit) begin
         free_in = wr_bus.free_val;
      end
      if (wr_bus.rate_we && hit) begin
         rate_in = wr_bus.rate_val;
      end
   end

   always_comb begin
      tok_in_merged = tok_in;
      if (tok_in.valid && active) begin
         // The first cell always seeds the minimum; later cells take it only when strictly less.
         if (cell_index == '0 || free_ff < tok_in.min_time) begin
            tok_in_merged.min_time = free_ff;
            tok_in_merged.min_idx  = cell_index;
            tok_in_merged.min_rate = rate_ff;
         end
         if (!tok_in.found && free_ff <= threshold) begin
            tok_in_merged.found      = 1'b1;
            tok_in_merged.found_idx  = cell_index;
            tok_in_merged.found_rate = rate_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
         tok_ff  <= '0;
      end else begin
         free_ff <= free_in;
         tok_ff  <= tok_in_merged;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff <= rate_in;
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

>>> sim/tb_greedy_multi_server_job_dispatcher.sv
`timescale 1ns / 100ps

module tb_greedy_multi_server_job_dispatcher;
   import gmsd_pkg::*;

   typedef struct packed {
      idx_type  chosen_server;
      time_type start_time;
      time_type finish_time;
      time_type makespan;
      logic     batch_done;
   } dispatch_result_type;

   // Tracks the server pool as the dispatcher should see it and holds the
   // results still owed, oldest first.
   class dispatch_scoreboard;
      amt_type             rate_of[MAX_SERVERS];
      time_type            free_at[MAX_SERVERS];
      time_type            now_t;
      time_type            longest;
      logic [CNT_W-1:0]    server_count;
      dispatch_result_type owed_q[$];
      int                  failures;
      int                  jobs_checked;
      int                  loads_taken;
      int                  saturated;

      function new();
         foreach (rate_of[i]) rate_of[i] = '0;
         clear_times();
         server_count = CNT_W'(1);
         failures     = 0;
         jobs_checked = 0;
         loads_taken  = 0;
         saturated    = 0;
      endfunction

      function void clear_times();
         foreach (free_at[i]) free_at[i] = '0;
         now_t   = '0;
         longest = '0;
      endfunction

      function void write_server_count(logic [CNT_W-1:0] value);
         server_count = value;
      endfunction

      function int servers_in_use();
         if (server_count == 0) return 1;
         if (server_count > MAX_SERVERS) return MAX_SERVERS;
         return int'(server_count);
      endfunction

      function int outstanding();
         return owed_q.size();
      endfunction

      function void note_request(logic cmd, idx_type idx, amt_type amount, logic eob);
         int                  n;
         time_type            earliest;
         time_type            begin_t;
         idx_type             pick;
         logic [63:0]         sum;
         dispatch_result_type r;
         if (cmd == CMD_LOAD) begin
            rate_of[idx] = amount;
            loads_taken++;
            return;
         end
         n = servers_in_use();
         earliest = free_at[0];
         for (int i = 1; i < n; i++)
            if (free_at[i] < earliest) earliest = free_at[i];
         begin_t = (earliest > now_t) ? earliest : now_t;
         // Walk downwards so that the lowest eligible server is the one kept.
         pick = '0;
         for (int i = n - 1; i >= 0; i--)
            if (free_at[i] <= begin_t) pick = idx_type'(i);
         sum = 64'(begin_t) + 64'(rate_of[pick]) * 64'(amount);
         r.finish_time   = (sum[63:TIME_W] != 0) ? '1 : sum[TIME_W-1:0];
         free_at[pick]   = r.finish_time;
         now_t           = begin_t;
         if (r.finish_time > longest) longest = r.finish_time;
         r.chosen_server = pick;
         r.start_time    = begin_t;
         r.makespan      = longest;
         r.batch_done    = eob;
         owed_q.push_back(r);
         if (eob) clear_times();
      endfunction

      function void check_result(dispatch_result_type got);
         dispatch_result_type want;
         if (owed_q.size() == 0) begin
            $error("response with no job outstanding: server %0d, start %0d",
                   got.chosen_server, got.start_time);
            failures++;
            return;
         end
         want = owed_q.pop_front();
         jobs_checked++;
         if (want.finish_time == '1) saturated++;
         if (got.chosen_server !== want.chosen_server) begin
            $error("chosen_server: expected %0d, actual %0d",
                   want.chosen_server, got.chosen_server);
            failures++;
         end
         if (got.start_time !== want.start_time) begin
            $error("start_time: expected %0d, actual %0d", want.start_time, got.start_time);
            failures++;
         end
         if (got.finish_time !== want.finish_time) begin
            $error("finish_time: expected %0d, actual %0d", want.finish_time, got.finish_time);
            failures++;
         end
         if (got.makespan !== want.makespan) begin
            $error("makespan: expected %0d, actual %0d", want.makespan, got.makespan);
            failures++;
         end
         if (got.batch_done !== want.batch_done) begin
            $error("batch_done: expected %0d, actual %0d", want.batch_done, got.batch_done);
            failures++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid;
   logic             req_ready;
   logic             req_cmd;
   logic [5:0]       req_server_index;
   logic [9:0]       req_amount;
   logic             req_end_of_batch;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [5:0]       rsp_chosen_server;
   logic [31:0]      rsp_start_time;
   logic [31:0]      rsp_finish_time;
   logic [31:0]      rsp_makespan;
   logic             rsp_batch_done;
   logic             csr_write_enable;
   logic [6:0]       csr_write_data;

   dispatch_scoreboard  sb;
   dispatch_result_type observed;
   bit                  loaded[MAX_SERVERS];
   int                  burst_left;
   int                  requests_sent;
   int                  settings_written;
   bit                  long_hold_request;
   bit                  long_hold_done;

   greedy_multi_server_job_dispatcher dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_server_index  (req_server_index),
      .req_amount        (req_amount),
      .req_end_of_batch  (req_end_of_batch),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_chosen_server (rsp_chosen_server),
      .rsp_start_time    (rsp_start_time),
      .rsp_finish_time   (rsp_finish_time),
      .rsp_makespan      (rsp_makespan),
      .rsp_batch_done    (rsp_batch_done),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            observed.chosen_server = rsp_chosen_server;
            observed.start_time    = rsp_start_time;
            observed.finish_time   = rsp_finish_time;
            observed.makespan      = rsp_makespan;
            observed.batch_done    = rsp_batch_done;
            sb.check_result(observed);
         end
         if (req_valid && req_ready)
            sb.note_request(req_cmd, req_server_index, req_amount, req_end_of_batch);
      end
   end

   task automatic send_request(logic cmd, idx_type idx, amt_type amount, logic eob);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_server_index <= idx;
      req_amount       <= amount;
      req_end_of_batch <= eob;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_load(idx_type idx, amt_type rate, logic eob);
      loaded[idx] = 1'b1;
      send_request(CMD_LOAD, idx, rate, eob);
   endtask

   task automatic send_job(amt_type amount, logic eob);
      send_request(CMD_JOB, idx_type'($urandom), amount, eob);
   endtask

   // Bursts of back-to-back requests separated by gaps, some of them empty.
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
   endtask

   // The count register is only touched once the block has drained.
   task automatic set_server_count(logic [CNT_W-1:0] value);
      @(negedge clock) req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.write_server_count(value);
      settings_written++;
      burst_left = 0;
   endtask

   function automatic amt_type pick_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2, 3: return amt_type'($urandom_range(1, 15));
         default: return amt_type'($urandom_range(0, 1023));
      endcase
   endfunction

   task automatic random_phase(int items);
      int n;
      int missing;
      n = sb.servers_in_use();
      repeat (items) begin
         // Every server in the pool gets a rate before any job can land on it.
         missing = -1;
         for (int i = n - 1; i >= 0; i--)
            if (!loaded[i]) missing = i;
         if (missing >= 0)
            send_load(idx_type'(missing), pick_value(), 1'($urandom));
         else if ($urandom_range(0, 3) == 0)
            send_load(idx_type'($urandom), pick_value(), 1'($urandom));
         else
            send_job(pick_value(), $urandom_range(0, 15) == 0);
         pace();
      end
   endtask

   // Receiver: stretches of steady, patchy or starved readiness, plus one long hold.
   initial begin
      int mode;
      int span;
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         if (long_hold_request && !long_hold_done) begin
            @(negedge clock) rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold_done = 1'b1;
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 60);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom);
               2: rsp_ready <= ($urandom_range(0, 4) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [CNT_W-1:0] plan[8];
      req_valid         = 1'b0;
      req_cmd           = CMD_LOAD;
      req_server_index  = '0;
      req_amount        = '0;
      req_end_of_batch  = 1'b0;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      burst_left        = 0;
      requests_sent     = 0;
      settings_written  = 0;
      long_hold_request = 1'b0;
      long_hold_done    = 1'b0;
      foreach (loaded[i]) loaded[i] = 1'b0;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // One server at its reset count; the end flag on a load is ignored.
      send_load(0, '1, 1'b1);
      send_job('1, 1'b0);
      send_job('0, 1'b0);
      send_job(10'd1, 1'b1);
      // A count of zero behaves as one; a zero rate finishes at the start.
      set_server_count(0);
      send_load(0, '0, 1'b0);
      send_job('1, 1'b0);
      send_job(10'd512, 1'b1);
      // Three servers at different speeds, then the pool shrinks and grows back
      // while servers one and two keep their free times.
      set_server_count(3);
      send_load(1, 10'd1, 1'b0);
      send_load(2, 10'd2, 1'b0);
      send_load(0, 10'd3, 1'b0);
      send_load(63, '1, 1'b1);
      send_job(10'd10, 1'b0);
      send_job(10'd10, 1'b0);
      send_job(10'd10, 1'b0);
      send_job(10'd5, 1'b0);
      set_server_count(1);
      send_job(10'd4, 1'b0);
      set_server_count(3);
      send_job(10'd7, 1'b0);
      send_job('0, 1'b1);

      plan = '{7'd64, 7'd127, 7'd2, 7'($urandom_range(3, 63)),
               7'd0, 7'd1, 7'd64, 7'($urandom_range(1, 63))};
      foreach (plan[p]) begin
         set_server_count(plan[p]);
         if (p == 2) begin
            random_phase(40);
            long_hold_request = 1'b1;
            random_phase(85);
         end else begin
            random_phase(125);
         end
      end

      // A short batch on the slowest single server builds up large times.
      set_server_count(1);
      send_load(0, '1, 1'b0);
      repeat (30) begin
         send_job('1, 1'b0);
         pace();
      end
      send_job('1, 1'b1);

      @(negedge clock) req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Run covered %0d requests: %0d jobs checked, %0d rate loads, %0d count writes.",
               requests_sent, sb.jobs_checked, sb.loads_taken, settings_written);
      $display("Saturated finish times: %0d; long receiver hold exercised: %0d.",
               sb.saturated, long_hold_done);
      if (sb.failures == 0 && sb.outstanding() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
